/* src/lsti_pkg.sv */
// Package for the leaf search / triangle interpolation block.
// Shared constants, types and controller-to-datapath command/status structs.
`default_nettype none
package lsti_pkg;
  localparam int MaxLeaves = 1024;
  localparam int SlotW = 10;
  localparam int CountW = 11;

  typedef struct packed {
    logic load_wr;    // write the input request into the table
    logic query_cap;  // capture point and clear the hit register
    logic scan_rd;    // issue a table read at scan_addr
    logic [SlotW-1:0] scan_addr;
    logic scan_chk;   // compare the registered read data against the point
    logic hit_rd;     // read the hit entry
    logic [3:0] ip_step; // interpolation step one-hot
  } lsti_cmd_t;

  typedef struct packed {
    logic found;
  } lsti_sts_t;
endpackage
`default_nettype wire

/* src/lsti_ctrl.sv */
// Controller: sequences load writes, the table scan and the interpolation.
// Depends on lsti_pkg.
`default_nettype none
module lsti_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_fire,
  input  wire logic in_mode,
  input  wire logic [lsti_pkg::CountW-1:0] leaf_count,
  input  wire logic out_busy,
  output logic in_rdy,
  output logic res_load,
  output lsti_pkg::lsti_cmd_t cmd
);
  import lsti_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DRAIN = 3'd2,
                         S_HIT = 3'd3, S_IP = 3'd4, S_OUT = 3'd5;
  logic [2:0] state, state_next;
  logic [CountW-1:0] cnt, cnt_next, lim;
  logic [3:0] step, step_next;
  logic chk, chk_next;

  assign lim = (leaf_count > CountW'(MaxLeaves)) ? CountW'(MaxLeaves) : leaf_count;
  assign in_rdy = (state == S_IDLE);

  always_comb begin
    state_next = state; cnt_next = cnt; step_next = step; chk_next = 1'b0;
    cmd = '0; res_load = 1'b0;
    cmd.scan_chk = chk;
    cmd.scan_addr = cnt[SlotW-1:0];
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_mode) begin
            cmd.query_cap = 1'b1; cnt_next = '0; state_next = S_SCAN;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      S_SCAN: begin
        if (cnt < lim) begin
          cmd.scan_rd = 1'b1; chk_next = 1'b1; cnt_next = cnt + 1'b1;
        end else begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_HIT;
      S_HIT: begin
        cmd.hit_rd = 1'b1; step_next = 4'b0001; state_next = S_IP;
      end
      S_IP: begin
        cmd.ip_step = step; step_next = {step[2:0], 1'b0};
        if (step[3]) state_next = S_OUT;
      end
      S_OUT: begin
        if (!out_busy) begin
          res_load = 1'b1; state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; cnt <= '0; step <= '0; chk <= 1'b0;
    end else begin
      state <= state_next; cnt <= cnt_next; step <= step_next; chk <= chk_next;
    end
  end
endmodule
`default_nettype wire

/* src/lsti_dp.sv */
// Datapath: leaf table memory, containment compare, triangle interpolation.
// Depends on lsti_pkg.
`default_nettype none
module lsti_dp (
  input  wire logic clk,
  input  wire logic rst,
  input  wire lsti_pkg::lsti_cmd_t cmd,
  input  wire logic [lsti_pkg::SlotW-1:0] leaf_slot,
  input  wire logic [4:0] load_level,
  input  wire logic signed [31:0] load_center_x,
  input  wire logic signed [31:0] load_center_y,
  input  wire logic signed [31:0] corner_ll,
  input  wire logic signed [31:0] corner_lr,
  input  wire logic signed [31:0] corner_ur,
  input  wire logic signed [31:0] corner_ul,
  input  wire logic signed [31:0] point_x,
  input  wire logic signed [31:0] point_y,
  output lsti_pkg::lsti_sts_t sts,
  output logic [lsti_pkg::SlotW-1:0] hit_idx,
  output logic signed [31:0] value
);
  import lsti_pkg::*;
  localparam int EW = 5 + 6*32;
  logic [EW-1:0] mem [MaxLeaves];
  logic [EW-1:0] rd;
  logic [SlotW-1:0] rd_addr, chk_addr;
  logic signed [31:0] px, py;
  logic found;

  always_ff @(posedge clk) begin
    if (cmd.load_wr)
      mem[leaf_slot] <= {load_level, load_center_x, load_center_y,
                         corner_ll, corner_lr, corner_ur, corner_ul};
  end
  assign rd_addr = cmd.hit_rd ? hit_idx : cmd.scan_addr;
  always_ff @(posedge clk) begin
    if (cmd.scan_rd || cmd.hit_rd)
      rd <= mem[rd_addr];
    chk_addr <= cmd.scan_addr;
  end

  // unpack read data
  logic [4:0] e_lv, lv;
  logic signed [31:0] e_cx, e_cy, e_ll, e_lr, e_ur, e_ul;
  assign {e_lv, e_cx, e_cy, e_ll, e_lr, e_ur, e_ul} = rd;
  assign lv = (e_lv > 5'd30) ? 5'd30 : e_lv;

  // containment test in 34-bit signed
  logic signed [33:0] w, xlo, xhi, ylo, yhi, pxe, pye;
  logic inside_c;
  assign w = 34'sd1 <<< (5'd30 - lv);
  assign xlo = 34'(e_cx) - w;
  assign xhi = 34'(e_cx) + w;
  assign ylo = 34'(e_cy) - w;
  assign yhi = 34'(e_cy) + w;
  assign pxe = 34'(px);
  assign pye = 34'(py);
  assign inside_c = (pxe >= xlo) && (pxe <= xhi) && (pye > ylo) && (pye <= yhi);

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0; hit_idx <= '0;
    end else if (cmd.query_cap) begin
      found <= 1'b0; hit_idx <= '0;
    end else if (cmd.scan_chk && inside_c) begin
      found <= 1'b1; hit_idx <= chk_addr;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.query_cap) begin
      px <= point_x; py <= point_y;
    end
  end
  assign sts.found = found;

  // interpolation: step0 deltas, step1 products, step2 sum/round, step3 sat
  logic signed [33:0] dx, dy, ca, cb;
  logic [4:0] sh;
  logic signed [67:0] p1, p2;
  logic signed [69:0] acc;
  logic signed [31:0] ll_r;
  always_ff @(posedge clk) begin
    if (cmd.ip_step[0]) begin
      dx <= pxe - xlo;
      dy <= pye - ylo;
      sh <= 5'd31 - lv;
      ll_r <= e_ll;
      if ((pxe - xlo) >= (pye - ylo)) begin
        ca <= 34'(e_lr) - 34'(e_ll); cb <= 34'(e_ur) - 34'(e_lr);
      end else begin
        ca <= 34'(e_ur) - 34'(e_ul); cb <= 34'(e_ul) - 34'(e_ll);
      end
    end
    if (cmd.ip_step[1]) begin
      p1 <= ca * dx;
      p2 <= cb * dy;
    end
    if (cmd.ip_step[2])
      acc <= (70'(p1) + 70'(p2) + (70'sd1 <<< (sh - 5'd1))) >>> sh;
    if (cmd.ip_step[3]) begin
      if (!found) value <= '0;
      else if ((acc + 70'(ll_r)) > 70'sd2147483647) value <= 32'sh7fffffff;
      else if ((acc + 70'(ll_r)) < -70'sd2147483648) value <= 32'sh80000000;
      else value <= 32'(acc + 70'(ll_r));
    end
  end
endmodule
`default_nettype wire

/* src/leaf_search_triangle_interpolation_top.sv */
// Leaf search with triangle interpolation, top level.
// Loads are written to the table as they are accepted. A query scans min(leaf_count,1024)
// leaves with one table read per leaf from the single read port of the leaf memory.
// One request in flight at a time; tready drops while a query is busy.
// rst (synchronous, high) clears control and leaf_count; table is not cleared.
`default_nettype none
module leaf_search_triangle_interpolation_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic s_tvalid,
  output logic s_tready,
  // tdata: mode, leaf_slot, load_level, load_center_x, load_center_y,
  // corner_ll, corner_lr, corner_ur, corner_ul, point_x, point_y (272 bits)
  input  wire logic [271:0] s_tdata,
  input  wire logic s_tlast,   // last_query
  output logic m_tvalid,
  input  wire logic m_tready,
  // tdata: found, leaf_index, value; zero pad to 48 bits
  output logic [47:0] m_tdata,
  output logic m_tlast,        // last_result
  input  wire logic psel,
  input  wire logic penable,
  input  wire logic pwrite,
  input  wire logic [2:0] paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import lsti_pkg::*;
  localparam logic [2:0] RegLeafCount = 3'd0;

  logic [CountW-1:0] leaf_count;
  logic in_fire, res_load, last_r;
  lsti_cmd_t cmd;
  lsti_sts_t sts;
  logic [SlotW-1:0] hit_idx;
  logic signed [31:0] value;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) leaf_count <= '0;
    else if (psel && penable && pwrite && paddr == RegLeafCount)
      leaf_count <= pwdata[CountW-1:0];
  end
  assign prdata = (paddr == RegLeafCount) ? 32'(leaf_count) : 32'd0;

  assign in_fire = s_tvalid && s_tready;
  always_ff @(posedge clk) begin
    if (in_fire) last_r <= s_tlast;
  end

  lsti_ctrl u_ctrl (
    .clk, .rst, .in_fire, .in_mode(s_tdata[0]), .leaf_count,
    .out_busy(m_tvalid && !m_tready), .in_rdy(s_tready), .res_load, .cmd
  );

  lsti_dp u_dp (
    .clk, .rst, .cmd,
    .leaf_slot(s_tdata[10:1]), .load_level(s_tdata[15:11]),
    .load_center_x(s_tdata[47:16]), .load_center_y(s_tdata[79:48]),
    .corner_ll(s_tdata[111:80]), .corner_lr(s_tdata[143:112]),
    .corner_ur(s_tdata[175:144]), .corner_ul(s_tdata[207:176]),
    .point_x(s_tdata[239:208]), .point_y(s_tdata[271:240]),
    .sts, .hit_idx, .value
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (res_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (res_load) begin
      m_tdata <= {5'd0, value, (sts.found ? hit_idx : SlotW'(0)), sts.found};
      m_tlast <= last_r;
    end
  end
endmodule
`default_nettype wire
